// ===== design/assert_macros.svh =====
// Assertion macros shared by the scan obstacle avoidance steering block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge.
`define SAOS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define SAOS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define SAOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/saos_pkg.sv =====
// Package for the scan obstacle avoidance steering block.
// Holds widths, register indexes, reset values, shared types and helpers.
// No dependencies.
package saos_pkg;

    localparam int MAX_SAMPLES_DEF = 512;
    localparam int QUEUE_DEPTH     = 2;

    localparam int RANGE_W     = 16;
    localparam int RND_W       = 6;
    localparam int SPEED_W     = 16;
    localparam int TURN_W      = 9;
    localparam int DEG_W       = 8;
    localparam int HOLD_W      = 8;
    localparam int COUNT_REG_W = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    localparam logic [DEG_W-1:0] TURN_LIMIT = 8'd180;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRONT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVOID_TURN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVOID_HOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_HOLD  = 3'd5;

    localparam logic [RANGE_W-1:0]     RST_MIN_FRONT    = 16'd750;
    localparam logic [SPEED_W-1:0]     RST_CRUISE_SPEED = 16'd400;
    localparam logic [DEG_W-1:0]       RST_AVOID_TURN   = 8'd60;
    localparam logic [COUNT_REG_W-1:0] RST_SCAN_LEN     = 10'd361;
    localparam logic [HOLD_W-1:0]      RST_AVOID_HOLD   = 8'd15;
    localparam logic [HOLD_W-1:0]      RST_RANDOM_HOLD  = 8'd50;

    typedef struct packed {
        logic [RANGE_W-1:0]     min_front_distance;
        logic [SPEED_W-1:0]     cruise_speed;
        logic [DEG_W-1:0]       avoid_turn_deg;
        logic [COUNT_REG_W-1:0] scan_len;
        logic [HOLD_W-1:0]      avoid_hold;
        logic [HOLD_W-1:0]      random_hold;
    } t_cfg;

    typedef struct packed {
        logic                    obstacle;
        logic                    left_nearer;
        logic signed [RND_W-1:0] random_turn;
    } t_scan_summary;

    function automatic logic [HOLD_W-1:0] hold_value(input logic [HOLD_W-1:0] h);
        return (h == '0) ? HOLD_W'(1) : h;
    endfunction

endpackage

// ===== design/saos_front.sv =====
// Front part: accepts range samples, keeps the per-scan obstacle flag and side
// minimums, and pushes one scan summary per finished scan. Depends on saos_pkg.
`include "assert_macros.svh"
module saos_front #(
    parameter int MAX_SAMPLES = saos_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  saos_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [saos_pkg::RANGE_W-1:0]        i_range,
    input  logic signed [saos_pkg::RND_W-1:0]   i_random_turn,
    input  logic                                i_full,
    output logic                                o_push,
    output saos_pkg::t_scan_summary             o_summary
);
    import saos_pkg::*;

    localparam int IW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int EW = (CW > COUNT_REG_W) ? CW : COUNT_REG_W;

    logic [IW-1:0]      r_index, n_index;
    logic               r_obstacle, n_obstacle;
    logic [RANGE_W-1:0] r_left, n_left;
    logic [RANGE_W-1:0] r_right, n_right;

    logic [EW-1:0]      w_count_raw;
    logic [EW-1:0]      w_count;
    logic [EW-1:0]      w_half;
    logic [EW-1:0]      w_index;
    logic [EW-1:0]      w_index_inc;
    logic               w_last;
    logic               w_accept;
    logic               w_obstacle;
    logic [RANGE_W-1:0] w_left;
    logic [RANGE_W-1:0] w_right;

    always_comb begin
        w_count_raw = EW'(i_cfg.scan_len);
        if (w_count_raw < EW'(2)) begin
            w_count = EW'(2);
        end else if (w_count_raw > EW'(MAX_SAMPLES)) begin
            w_count = EW'(MAX_SAMPLES);
        end else begin
            w_count = w_count_raw;
        end
        w_half      = w_count >> 1;
        w_index     = EW'(r_index);
        w_index_inc = w_index + EW'(1);
        w_last      = (w_index_inc >= w_count);

        o_ready  = !i_full;
        w_accept = i_valid && o_ready;

        w_obstacle = r_obstacle || (i_range < i_cfg.min_front_distance);
        w_left     = r_left;
        w_right    = r_right;
        if ((w_index > w_half) && (i_range < r_left)) begin
            w_left = i_range;
        end
        if ((w_index < w_half) && (i_range < r_right)) begin
            w_right = i_range;
        end

        n_index    = r_index;
        n_obstacle = r_obstacle;
        n_left     = r_left;
        n_right    = r_right;
        if (w_accept) begin
            if (w_last) begin
                n_index    = '0;
                n_obstacle = 1'b0;
                n_left     = '1;
                n_right    = '1;
            end else begin
                n_index    = w_index_inc[IW-1:0];
                n_obstacle = w_obstacle;
                n_left     = w_left;
                n_right    = w_right;
            end
        end

        o_push                = w_accept && w_last;
        o_summary.obstacle    = w_obstacle;
        o_summary.left_nearer = (w_left < w_right);
        o_summary.random_turn = i_random_turn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= '0;
            r_obstacle <= 1'b0;
            r_left     <= '1;
            r_right    <= '1;
        end else begin
            r_index    <= n_index;
            r_obstacle <= n_obstacle;
            r_left     <= n_left;
            r_right    <= n_right;
        end
    end

    `SAOS_ASSERT_ALWAYS(a_index_in_range, EW'(r_index) < EW'(MAX_SAMPLES), "index out of range")
    `SAOS_ASSERT_IMPL(a_push_needs_room, o_push, !i_full, "summary pushed into a full queue")
    `SAOS_ASSERT_NEXT(a_scan_restarts, o_push, (r_index == '0) && !r_obstacle, "no restart")

endmodule

// ===== design/saos_fifo.sv =====
// Short queue of scan summaries between the front and back parts.
// Depends on saos_pkg for the summary type.
`include "assert_macros.svh"
module saos_fifo #(
    parameter int DEPTH = saos_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  saos_pkg::t_scan_summary i_data,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_valid,
    output saos_pkg::t_scan_summary o_data
);
    import saos_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_scan_summary r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count, n_count;

    always_comb begin
        o_full  = (r_count == NW'(DEPTH));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `SAOS_ASSERT_ALWAYS(a_count_bound, r_count <= NW'(DEPTH), "queue count beyond depth")
    `SAOS_ASSERT_IMPL(a_no_underflow, i_pop, o_valid, "pop from an empty queue")
    `SAOS_ASSERT_IMPL(a_no_overflow, i_push && !i_pop, !o_full, "push into a full queue")

endmodule

// ===== design/saos_back.sv =====
// Back part: turns each scan summary into a speed and turn command, keeps the
// avoid and random hold counters, and drives the output register. Uses saos_pkg.
`include "assert_macros.svh"
module saos_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  saos_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    input  saos_pkg::t_scan_summary             i_summary,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [saos_pkg::SPEED_W-1:0]        o_speed,
    output logic signed [saos_pkg::TURN_W-1:0]  o_turn,
    output logic                                o_avoiding
);
    import saos_pkg::*;

    logic [HOLD_W-1:0]        r_avoid_rem, n_avoid_rem;
    logic [HOLD_W-1:0]        r_random_rem, n_random_rem;
    logic signed [TURN_W-1:0] r_held, n_held;
    logic                     r_out_valid, n_out_valid;
    logic [SPEED_W-1:0]       r_speed, n_speed;
    logic                     r_avoiding, n_avoiding;

    logic [DEG_W-1:0]         w_mag_u;
    logic signed [TURN_W-1:0] w_mag;
    logic signed [TURN_W-1:0] w_rnd;
    logic [HOLD_W-1:0]        w_rem;
    logic                     w_load;

    always_comb begin
        w_mag_u = (i_cfg.avoid_turn_deg > TURN_LIMIT) ? TURN_LIMIT : i_cfg.avoid_turn_deg;
        w_mag   = $signed(TURN_W'(w_mag_u));
        w_rnd   = {{(TURN_W - RND_W){i_summary.random_turn[RND_W-1]}}, i_summary.random_turn};
        w_load  = i_valid && (!r_out_valid || i_tready);
        o_pop   = w_load;

        n_avoid_rem  = r_avoid_rem;
        n_random_rem = r_random_rem;
        n_held       = r_held;
        n_speed      = r_speed;
        n_avoiding   = r_avoiding;
        n_out_valid  = r_out_valid && !i_tready;
        w_rem        = '0;

        if (w_load) begin
            n_out_valid = 1'b1;
            if (i_summary.obstacle || (r_avoid_rem != '0)) begin
                n_speed    = '0;
                n_avoiding = 1'b1;
                w_rem      = r_avoid_rem;
                if (r_avoid_rem == '0) begin
                    w_rem        = hold_value(i_cfg.avoid_hold);
                    n_random_rem = '0;
                    n_held       = i_summary.left_nearer ? -w_mag : w_mag;
                end
                n_avoid_rem = w_rem - HOLD_W'(1);
            end else begin
                n_speed    = i_cfg.cruise_speed;
                n_avoiding = 1'b0;
                w_rem      = r_random_rem;
                if (r_random_rem == '0) begin
                    w_rem  = hold_value(i_cfg.random_hold);
                    n_held = w_rnd;
                end
                n_random_rem = w_rem - HOLD_W'(1);
            end
        end

        o_tvalid   = r_out_valid;
        o_speed    = r_speed;
        o_turn     = r_held;
        o_avoiding = r_avoiding;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avoid_rem  <= '0;
            r_random_rem <= '0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_avoid_rem  <= n_avoid_rem;
            r_random_rem <= n_random_rem;
            r_held       <= n_held;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_speed    <= n_speed;
        r_avoiding <= n_avoiding;
    end

    `SAOS_ASSERT_IMPL(a_avoid_stops, r_out_valid && r_avoiding, r_speed == '0, "moving while avoiding")
    `SAOS_ASSERT_ALWAYS(a_avoid_rem_bound, r_avoid_rem != '1, "avoid hold counter wrapped")
    `SAOS_ASSERT_NEXT(a_avoid_resets_random, w_load && n_avoiding, r_random_rem == '0, "random hold kept during avoidance")

endmodule

// ===== design/scan_obstacle_avoid_steer.sv =====
// Scan obstacle avoidance steering: one range sample per cycle while the queue has room, one command per scan.
// A scan's summary enters the queue when its last sample is accepted; the back part then registers its command.
// Throughput: one sample per cycle; the back part issues one queued command per cycle unless the output is stalled.
// The front stalls only when the two-entry summary queue is full.
// Reset (synchronous, active low) loads register defaults and clears scan and hold state.
// Depends on saos_pkg, saos_front, saos_fifo and saos_back.
module scan_obstacle_avoid_steer #(
    parameter int MAX_SAMPLES = saos_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [saos_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [saos_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // range_mm [15:0], random_turn_deg [21:16], zero [23:22]
    input  logic [saos_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // speed_mm_s [15:0], turn_rate_deg [24:16], zero [31:25]
    output logic [saos_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // avoiding [0]
    output logic                                m_axis_tuser
);
    import saos_pkg::*;

    t_cfg                     r_cfg;
    t_scan_summary            w_push_data;
    t_scan_summary            w_pop_data;
    logic                     w_push;
    logic                     w_full;
    logic                     w_pop;
    logic                     w_queue_valid;
    logic [SPEED_W-1:0]       w_speed;
    logic signed [TURN_W-1:0] w_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_front_distance <= RST_MIN_FRONT;
            r_cfg.cruise_speed       <= RST_CRUISE_SPEED;
            r_cfg.avoid_turn_deg     <= RST_AVOID_TURN;
            r_cfg.scan_len           <= RST_SCAN_LEN;
            r_cfg.avoid_hold         <= RST_AVOID_HOLD;
            r_cfg.random_hold        <= RST_RANDOM_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_FRONT:    r_cfg.min_front_distance <= i_cfg_data[RANGE_W-1:0];
                REG_CRUISE_SPEED: r_cfg.cruise_speed       <= i_cfg_data[SPEED_W-1:0];
                REG_AVOID_TURN:   r_cfg.avoid_turn_deg     <= i_cfg_data[DEG_W-1:0];
                REG_SCAN_LEN:     r_cfg.scan_len           <= i_cfg_data[COUNT_REG_W-1:0];
                REG_AVOID_HOLD:   r_cfg.avoid_hold         <= i_cfg_data[HOLD_W-1:0];
                REG_RANDOM_HOLD:  r_cfg.random_hold        <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    saos_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_range       (s_axis_tdata[RANGE_W-1:0]),
        .i_random_turn ($signed(s_axis_tdata[RANGE_W+RND_W-1:RANGE_W])),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_summary     (w_push_data)
    );

    saos_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_data  (w_pop_data)
    );

    saos_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (w_queue_valid),
        .i_summary  (w_pop_data),
        .o_pop      (w_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_speed    (w_speed),
        .o_turn     (w_turn),
        .o_avoiding (m_axis_tuser)
    );

    assign m_axis_tdata = {{(M_TDATA_W - SPEED_W - TURN_W){1'b0}}, w_turn, w_speed};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for scan_obstacle_avoid_steer: range samples in, commands out.
// It runs a directed table, then randomized phases with register changes and random handshake gaps.
// Commands are checked against typed table rows or the in-bench predictor. Depends on saos_pkg and the block's RTL.
module tb;
    import saos_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 6;
    localparam int RAND_ITEMS  = 520;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed;
        logic signed [TURN_W-1:0]  turn;
        logic                      avoiding;
    } t_steer_cmd;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        logic [RANGE_W-1:0]       rng;
        logic signed [RND_W-1:0]  rnd;
        logic                     typed;
        t_steer_cmd               want;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic                    m_axis_tuser;

    scan_obstacle_avoid_steer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int unsigned cycles   = 0;
    int unsigned errors   = 0;
    int unsigned n_sent   = 0;
    int unsigned n_cmds   = 0;
    int unsigned n_avoid  = 0;
    int unsigned n_writes = 0;
    bit          calm     = 1'b0;

    t_steer_cmd pending_cmds[$];

    // Register copies and scan state of the predictor.
    logic [RANGE_W-1:0]     cfg_thr;
    logic [SPEED_W-1:0]     cfg_cruise;
    logic [DEG_W-1:0]       cfg_turn;
    logic [COUNT_REG_W-1:0] cfg_count;
    logic [HOLD_W-1:0]      cfg_avoid_hold;
    logic [HOLD_W-1:0]      cfg_random_hold;
    logic [8:0]             scan_pos;
    logic                   scan_blocked;
    logic [RANGE_W-1:0]     left_near;
    logic [RANGE_W-1:0]     right_near;
    logic [HOLD_W-1:0]      avoid_scans;
    logic [HOLD_W-1:0]      wander_scans;
    logic signed [TURN_W-1:0] heading;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic steer_predict(input logic [RANGE_W-1:0] rng,
                                 input logic signed [RND_W-1:0] rnd,
                                 output bit fired, output t_steer_cmd cmd);
        int unsigned n;
        int unsigned half;
        logic [TURN_W-1:0] mag;
        n = (cfg_count < 2) ? 2 : (cfg_count > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : cfg_count;
        half = n / 2;
        fired = 1'b0;
        cmd = '0;
        if (rng < cfg_thr) scan_blocked = 1'b1;
        if (scan_pos > half) begin
            if (rng < left_near) left_near = rng;
        end else if (scan_pos < half) begin
            if (rng < right_near) right_near = rng;
        end
        if (scan_pos + 1 < n) begin
            scan_pos = scan_pos + 9'd1;
            return;
        end
        if (scan_blocked || avoid_scans != 0) begin
            if (avoid_scans == 0) begin
                mag = (cfg_turn > TURN_LIMIT) ? TURN_W'(TURN_LIMIT) : TURN_W'(cfg_turn);
                avoid_scans = (cfg_avoid_hold == 0) ? HOLD_W'(1) : cfg_avoid_hold;
                wander_scans = '0;
                heading = (left_near < right_near) ? -$signed(mag) : $signed(mag);
            end
            avoid_scans = avoid_scans - HOLD_W'(1);
            cmd.speed = '0;
            cmd.avoiding = 1'b1;
        end else begin
            if (wander_scans == 0) begin
                heading = TURN_W'(rnd);
                wander_scans = (cfg_random_hold == 0) ? HOLD_W'(1) : cfg_random_hold;
            end
            wander_scans = wander_scans - HOLD_W'(1);
            cmd.speed = cfg_cruise;
            cmd.avoiding = 1'b0;
        end
        cmd.turn = heading;
        fired = 1'b1;
        scan_pos = '0;
        scan_blocked = 1'b0;
        left_near = '1;
        right_near = '1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MIN_FRONT:    cfg_thr = data;
            REG_CRUISE_SPEED: cfg_cruise = data;
            REG_AVOID_TURN:   cfg_turn = data[DEG_W-1:0];
            REG_SCAN_LEN:     cfg_count = data[COUNT_REG_W-1:0];
            REG_AVOID_HOLD:   cfg_avoid_hold = data[HOLD_W-1:0];
            REG_RANDOM_HOLD:  cfg_random_hold = data[HOLD_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic signed [RND_W-1:0] rnd,
                               output bit fired, output t_steer_cmd cmd);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, rnd, rng};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        steer_predict(rng, rnd, fired, cmd);
    endtask

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [15:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row smp_row(input logic [15:0] rng, input logic signed [5:0] rnd);
        t_row r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.rng = rng;
        r.rnd = rnd;
        return r;
    endfunction

    function automatic t_row chk_row(input logic [15:0] rng, input logic signed [5:0] rnd,
                                     input logic [15:0] speed, input logic signed [8:0] turn,
                                     input logic avoiding);
        t_row r;
        r = smp_row(rng, rnd);
        r.typed = 1'b1;
        r.want.speed = speed;
        r.want.turn = turn;
        r.want.avoiding = avoiding;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int unsigned roll;
        v = CFG_DATA_W'($urandom);
        roll = $urandom_range(0, 19);
        case (idx)
            REG_MIN_FRONT: begin
                if (roll == 0) v = '0;
                else if (roll == 1) v = '1;
                else if (roll > 4) v = CFG_DATA_W'($urandom_range(200, 3000));
            end
            REG_CRUISE_SPEED: begin
                if (roll == 0) v = '0;
                else if (roll == 1) v = '1;
            end
            REG_AVOID_TURN:
                v[DEG_W-1:0] = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd180 :
                               (roll == 2) ? 8'($urandom_range(181, 255)) :
                               8'($urandom_range(1, 179));
            REG_SCAN_LEN:
                v[COUNT_REG_W-1:0] = (roll == 0) ? 10'd0 : (roll == 1) ? 10'd1 :
                                     (roll == 2) ? 10'd2 :
                                     (roll == 3) ? ($urandom_range(0, 1) ? 10'd512 : 10'd1023) :
                                     10'($urandom_range(3, 12));
            REG_AVOID_HOLD, REG_RANDOM_HOLD:
                v[HOLD_W-1:0] = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 :
                                8'($urandom_range(1, 6));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [RANGE_W-1:0] draw_range(input int unsigned obstacle_pct);
        if ($urandom_range(0, 99) < obstacle_pct) begin
            if (cfg_thr == 0) return RANGE_W'($urandom);
            case ($urandom_range(0, 2))
                0: return '0;
                1: return cfg_thr - RANGE_W'(1);
                default: return RANGE_W'($urandom_range(0, cfg_thr - 1));
            endcase
        end
        case ($urandom_range(0, 9))
            0: return '1;
            1: return cfg_thr;
            default: return RANGE_W'($urandom_range(cfg_thr, 16'hFFFF));
        endcase
    endfunction

    function automatic logic signed [RND_W-1:0] draw_rnd();
        int v;
        if ($urandom_range(0, 9) == 0) return RND_W'($urandom);
        v = int'($urandom_range(0, 40)) - 20;
        return RND_W'(v);
    endfunction

    // Result side: random stalls, then compare each command with the oldest prediction.
    initial begin
        int unsigned stall;
        t_steer_cmd want;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            n_cmds++;
            if (m_axis_tuser) n_avoid++;
            if (pending_cmds.size() == 0) begin
                report($sformatf("command 0x%08h with no prediction waiting", m_axis_tdata));
            end else begin
                want = pending_cmds.pop_front();
                if (m_axis_tdata[15:0] !== want.speed)
                    report($sformatf("speed %0d, predicted %0d", m_axis_tdata[15:0], want.speed));
                if (m_axis_tdata[24:16] !== want.turn)
                    report($sformatf("turn %0d, predicted %0d",
                                     $signed(m_axis_tdata[24:16]), want.turn));
                if (m_axis_tuser !== want.avoiding)
                    report($sformatf("avoiding %b, predicted %b", m_axis_tuser, want.avoiding));
                if (m_axis_tdata[31:25] !== '0)
                    report($sformatf("padding bits 0x%02h not zero", m_axis_tdata[31:25]));
            end
        end
    end

    initial begin
        t_row plan[$];
        bit fired;
        t_steer_cmd cmd;
        int unsigned n_directed;
        int unsigned rand_items;
        int unsigned obstacle_pct;
        int unsigned burst;
        logic [CFG_IDX_W-1:0] idx;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;

        cfg_thr = RST_MIN_FRONT;
        cfg_cruise = RST_CRUISE_SPEED;
        cfg_turn = RST_AVOID_TURN;
        cfg_count = RST_SCAN_LEN;
        cfg_avoid_hold = RST_AVOID_HOLD;
        cfg_random_hold = RST_RANDOM_HOLD;
        scan_pos = '0;
        scan_blocked = 1'b0;
        left_near = '1;
        right_near = '1;
        avoid_scans = '0;
        wander_scans = '0;
        heading = '0;

        plan = '{
            cfg_row(REG_SCAN_LEN, 16'd0),
            cfg_row(REG_AVOID_HOLD, 16'd0),
            smp_row(16'hFFFF, 6'sd0),
            chk_row(16'hFFFF, -6'sd20, 16'd400, -9'sd20, 1'b0),
            smp_row(16'd0, 6'sd31),
            chk_row(16'hFFFF, -6'sd32, 16'd0, 9'sd60, 1'b1),
            cfg_row(REG_SCAN_LEN, 16'd3),
            cfg_row(REG_AVOID_TURN, 16'd255),
            smp_row(16'd800, 6'sd0),
            smp_row(16'd0, 6'sd0),
            chk_row(16'd100, 6'sd5, 16'd0, -9'sd180, 1'b1),
            smp_row(16'd500, 6'sd0),
            smp_row(16'd900, 6'sd0),
            chk_row(16'd500, 6'sd0, 16'd0, 9'sd180, 1'b1),
            cfg_row(REG_MIN_FRONT, 16'd0),
            cfg_row(REG_RANDOM_HOLD, 16'd0),
            cfg_row(REG_CRUISE_SPEED, 16'hFFFF),
            cfg_row(REG_UNUSED, 16'hFFFF),
            smp_row(16'd0, 6'sd0),
            smp_row(16'd0, 6'sd0),
            chk_row(16'd0, 6'sd20, 16'hFFFF, 9'sd20, 1'b0),
            smp_row(16'd0, 6'sd0),
            smp_row(16'd0, 6'sd0),
            chk_row(16'd0, 6'sd31, 16'hFFFF, 9'sd31, 1'b0),
            cfg_row(REG_CRUISE_SPEED, 16'd0),
            smp_row(16'hFFFF, 6'sd0),
            smp_row(16'hFFFF, 6'sd0),
            chk_row(16'hFFFF, -6'sd32, 16'd0, -9'sd32, 1'b0),
            cfg_row(REG_MIN_FRONT, 16'hFFFF),
            cfg_row(REG_SCAN_LEN, 16'hFFFF),
            smp_row(16'hFFFF, 6'sd0),
            smp_row(16'hFFFE, 6'sd0),
            smp_row(16'hFFFF, 6'sd0),
            cfg_row(REG_SCAN_LEN, 16'd2),
            smp_row(16'd1234, 6'sd0)
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: typed rows carry their own command, the rest use the predictor.
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                drain_and_settle();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_sample(plan[k].rng, plan[k].rnd, fired, cmd);
                if (plan[k].typed) pending_cmds.push_back(plan[k].want);
                else if (fired) pending_cmds.push_back(cmd);
            end
        end
        n_directed = n_sent;

        // Random phases: new register values while idle, then a burst of samples.
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            drain_and_settle();
            calm = ($urandom_range(0, 2) == 0);
            obstacle_pct = $urandom_range(0, 30);
            repeat ($urandom_range(1, 3)) begin
                idx = CFG_IDX_W'($urandom_range(0, 7));
                write_reg(idx, pick_reg_value(idx));
            end
            burst = $urandom_range(4, 60);
            repeat (burst) begin
                if ($urandom_range(0, 59) == 0) drain_and_settle();
                send_sample(draw_range(obstacle_pct), draw_rnd(), fired, cmd);
                if (fired) pending_cmds.push_back(cmd);
                rand_items++;
            end
        end

        drain_and_settle();
        repeat (10) @(posedge i_clk);
        if (pending_cmds.size() != 0)
            report($sformatf("%0d predicted commands never arrived", pending_cmds.size()));

        $display("tb: %0d sample requests (%0d directed), %0d register writes",
                 n_sent, n_directed, n_writes);
        $display("tb: %0d command requests checked, %0d of them avoiding", n_cmds, n_avoid);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/saos_pkg.sv
design/saos_front.sv
design/saos_fifo.sv
design/saos_back.sv
design/scan_obstacle_avoid_steer.sv
tb/sv/tb.sv
